FILE: src/ptd_pkg.sv
// shared types for the trial-division primality tester
// command and status structs between ptd_ctrl and ptd_dp, divisor select codes
// no dependencies
package ptd_pkg;

  localparam int unsigned DATA_W     = 64;  // candidate field width on the input stream
  localparam int unsigned OUT_DATA_W = 8;   // result stream tdata, one flag padded to a byte

  // which divisor the next division uses
  typedef enum logic [1:0] {
    DIV_BASE,    // current 6k-1 divisor
    DIV_PAIR,    // current 6k+1 divisor
    DIV_NEXT     // next 6k-1 divisor, base advances at the same time
  } ptd_div_sel_e;

  typedef struct packed {
    logic         load;       // capture candidate, base divisor back to 5
    logic         div_start;  // begin one division
    ptd_div_sel_e div_sel;
  } ptd_cmd_t;

  typedef struct packed {
    logic n_le1;       // candidate is 0 or 1
    logic n_le3;       // candidate is 3 or less
    logic n_even;
    logic n_div3;      // candidate is a multiple of 3
    logic div_busy;
    logic rem_zero;    // last division left no remainder
    logic quo_lt_div;  // last quotient below its divisor
  } ptd_sts_t;

endpackage

FILE: src/primality_trial_division.sv
// primality tester by trial division: 0..3, even values and multiples of 3 settle in a screen,
// otherwise divisions by 6k-1 and 6k+1 until one leaves no remainder or the divisor squared
// passes the candidate. all divisions share one bit-serial divider; one candidate at a time.
// the result sits in an output register while the next request is taken.
// reset (async, active low) returns to idle with the result stream empty.
module primality_trial_division #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ptd_pkg::DATA_W-1:0]     s_axis_tdata_i,  // [63:0] candidate
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ptd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // [0] is_prime_flag, rest zero
);
  import ptd_pkg::*;

  ptd_cmd_t cmd;
  ptd_sts_t sts;
  logic     push;
  logic     flag;
  logic     out_free;
  logic     m_valid_q, m_valid_d;
  logic     m_flag_q;

  assign out_free = ~m_valid_q | m_axis_tready_i;

  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .push_o     (push),
    .flag_o     (flag),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ptd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (push) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_flag_q <= flag;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 1){1'b0}}, m_flag_q};

endmodule

FILE: src/ptd_dp.sv
// datapath of the primality tester: candidate, divisor base, a mod-3 check and a
// restoring divider that retires one quotient bit per cycle
// depends on ptd_pkg
module ptd_dp #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] n_i,
  input  ptd_pkg::ptd_cmd_t      cmd_i,
  output ptd_pkg::ptd_sts_t      sts_o
);
  import ptd_pkg::*;

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned CW     = $clog2(W);
  localparam int unsigned Digits = (W + 1) / 2;
  localparam int unsigned PadW   = 2 * Digits;

  localparam logic [W-1:0]  FiveC    = W'(5);
  localparam logic [W-1:0]  TwoC     = W'(2);
  localparam logic [W-1:0]  SixC     = W'(6);
  localparam logic [CW-1:0] LastBitC = CW'(W - 1);

  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  base_q, base_d;
  logic [W-1:0]  d_q, d_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;

  logic [W:0]    rem_sh;
  logic          sub_ok;
  logic [W:0]    rem_sub;
  logic [W-1:0]  div_sel;

  logic [PadW-1:0] n_pad;
  logic [1:0]      dig_res [Digits];

  // sum of two residues mod 3, each 0..2
  function automatic logic [1:0] mod3_add(logic [1:0] a, logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // 4 is 1 mod 3, so the residues of the base-4 digits add up to the candidate's
  always_comb begin
    n_pad = PadW'(n_q);
    for (int unsigned k = 0; k < Digits; k++) begin
      dig_res[k] = (n_pad[2*k +: 2] == 2'd3) ? 2'd0 : n_pad[2*k +: 2];
    end
    for (int unsigned step = 1; step < Digits; step = step * 2) begin
      for (int unsigned k = 0; k + step < Digits; k += 2 * step) begin
        dig_res[k] = mod3_add(dig_res[k], dig_res[k + step]);
      end
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_BASE:  div_sel = base_q;
      DIV_PAIR:  div_sel = base_q + TwoC;
      DIV_NEXT:  div_sel = base_q + SixC;
      default:   div_sel = base_q;
    endcase
  end

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, quo_q[W-1]};
  assign sub_ok  = (rem_sh >= {1'b0, d_q});
  assign rem_sub = rem_sh - {1'b0, d_q};

  always_comb begin
    n_d    = n_q;
    base_d = base_q;
    d_d    = d_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.load) begin
      n_d    = n_i;
      base_d = FiveC;
    end
    if (cmd_i.div_start) begin
      d_d    = div_sel;
      rem_d  = '0;
      quo_d  = n_q;
      cnt_d  = LastBitC;
      busy_d = 1'b1;
      if (cmd_i.div_sel == DIV_NEXT) begin
        base_d = div_sel;
      end
    end else if (busy_q) begin
      rem_d = sub_ok ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], sub_ok};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    base_q <= base_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    sts_o.n_le1      = (n_q[W-1:1] == '0);
    sts_o.n_le3      = (n_q[W-1:2] == '0);
    sts_o.n_even     = ~n_q[0];
    sts_o.n_div3     = (dig_res[0] == 2'd0);
    sts_o.div_busy   = busy_q;
    sts_o.rem_zero   = (rem_q == '0);
    sts_o.quo_lt_div = (quo_q < d_q);
  end

  property p_div_ends;
    @(posedge clk_i) disable iff (!rst_ni)
      (busy_q && !cmd_i.div_start && cnt_q == '0) |=> !busy_q;
  endproperty
  a_div_ends: assert property (p_div_ends) else $error("divider overran its bit count");

endmodule

FILE: src/ptd_ctrl.sv
// controller of the primality tester: screens small, even and multiple-of-3 candidates,
// then sequences divisions by 6k-1 and 6k+1 until a verdict
// depends on ptd_pkg
module ptd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              push_o,
  output logic              flag_o,
  output ptd_pkg::ptd_cmd_t cmd_o,
  input  ptd_pkg::ptd_sts_t sts_i
);
  import ptd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_WI   = 3'd3;
  localparam logic [2:0] S_WJ   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       flag_q, flag_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign flag_o     = flag_q;

  always_comb begin
    state_d         = state_q;
    flag_d          = flag_q;
    push_o          = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = DIV_BASE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        priority if (sts_i.n_le1) begin
          flag_d  = 1'b0;
          state_d = S_FIN;
        end else if (sts_i.n_le3) begin
          flag_d  = 1'b1;
          state_d = S_FIN;
        end else if (sts_i.n_even) begin
          flag_d  = 1'b0;
          state_d = S_FIN;
        end else if (sts_i.n_div3) begin
          flag_d  = 1'b0;
          state_d = S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_BASE;
          state_d         = S_WI;
        end
      end
      S_WI: begin
        // quotient below divisor means divisor squared exceeds the candidate
        if (!sts_i.div_busy) begin
          priority if (sts_i.quo_lt_div) begin
            flag_d  = 1'b1;
            state_d = S_FIN;
          end else if (sts_i.rem_zero) begin
            flag_d  = 1'b0;
            state_d = S_FIN;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_PAIR;
            state_d         = S_WJ;
          end
        end
      end
      S_WJ: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rem_zero) begin
            flag_d  = 1'b0;
            state_d = S_FIN;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_NEXT;
            state_d         = S_WI;
          end
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
  end

  property p_start_when_free;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_o.div_start |-> !sts_i.div_busy;
  endproperty
  a_start_when_free: assert property (p_start_when_free)
    else $error("division started while divider busy");

  property p_idle_divider;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_IDLE) |-> !sts_i.div_busy;
  endproperty
  a_idle_divider: assert property (p_idle_divider)
    else $error("divider still running with controller idle");

  property p_accept_screens;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o) |=> (state_q == S_CHK);
  endproperty
  a_accept_screens: assert property (p_accept_screens)
    else $error("accepted request not screened next cycle");

endmodule
